### rtl/rrsm_pkg.sv
`default_nettype none

package rrsm_pkg;

  // Command codes carried on in_tuser.
  typedef enum logic [1:0] {
    CMD_ADD      = 2'd0,
    CMD_READ_DIM = 2'd1,
    CMD_READ_FMT = 2'd2,
    CMD_CLEAR    = 2'd3
  } cmd_t;

  // Depth of each lookup table (dimension pairs and format codes).
  localparam int TBL_SLOTS = 16;
  localparam int TBL_IDX_W = (TBL_SLOTS > 1) ? $clog2(TBL_SLOTS) : 1;
  localparam int TBL_FILL_W = $clog2(TBL_SLOTS + 1);

  // Fixed field widths.
  localparam int SLOT_W = 4;
  localparam int COUNT_OUT_W = 5;
  localparam int ENTRY_W = 32;

  // Status flag bit positions.
  localparam int FLAG_ALT_SEEN = 0;
  localparam int FLAG_HEAD_SEEN = 1;
  localparam int FLAG_DIM_OVF = 2;
  localparam int FLAG_FMT_OVF = 3;

  // Request from the top level to one lookup table.
  typedef struct packed {
    logic                commit;
    logic                add;
    logic                clear;
    logic [ENTRY_W-1:0]  value;
    logic [SLOT_W-1:0]   slot;
  } tbl_req_t;

  // Table answer for the item currently being processed.
  typedef struct packed {
    logic [TBL_FILL_W-1:0] fill_nxt;
    logic                  ovf;
    logic [ENTRY_W-1:0]    rd_data;
  } tbl_resp_t;

endpackage

`default_nettype wire

### rtl/rrsm_table.sv
`default_nettype none

module rrsm_table (
  input  wire                 clk,
  input  wire                 rst_n,
  input  rrsm_pkg::tbl_req_t  req,
  output rrsm_pkg::tbl_resp_t resp
);

  logic [rrsm_pkg::ENTRY_W-1:0]    entries_r [rrsm_pkg::TBL_SLOTS];
  logic [rrsm_pkg::TBL_FILL_W-1:0] fill_r;
  logic [rrsm_pkg::TBL_FILL_W-1:0] fill_nxt;
  logic                            hit;
  logic                            full;
  logic                            do_insert;
  logic [rrsm_pkg::TBL_IDX_W-1:0]  wr_idx;
  logic [rrsm_pkg::TBL_IDX_W-1:0]  rd_idx;

  // Compare the new value against every filled slot in parallel.
  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < rrsm_pkg::TBL_SLOTS; i++) begin
      if ((rrsm_pkg::TBL_FILL_W'(i) < fill_r) && (entries_r[i] == req.value)) begin
        hit = 1'b1;
      end
    end
  end

  assign full = (fill_r == rrsm_pkg::TBL_FILL_W'(rrsm_pkg::TBL_SLOTS));
  assign do_insert = req.add && !hit && !full;
  assign wr_idx = rrsm_pkg::TBL_IDX_W'(fill_r);
  assign rd_idx = rrsm_pkg::TBL_IDX_W'(req.slot);

  // Fill count after this item.
  always_comb begin
    if (req.clear) begin
      fill_nxt = '0;
    end else if (do_insert) begin
      fill_nxt = fill_r + rrsm_pkg::TBL_FILL_W'(1);
    end else begin
      fill_nxt = fill_r;
    end
  end

  // Answers for the result of this item.
  always_comb begin
    resp.fill_nxt = fill_nxt;
    resp.ovf = req.add && !hit && full;
    if (8'(req.slot) < 8'(fill_r)) begin
      resp.rd_data = entries_r[rd_idx];
    end else begin
      resp.rd_data = '0;
    end
  end

  // Fill count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (req.commit) begin
      fill_r <= fill_nxt;
    end
  end

  // Table storage; contents stay undefined until written.
  always_ff @(posedge clk) begin
    if (req.commit && do_insert) begin
      entries_r[wr_idx] <= req.value;
    end
  end

endmodule

`default_nettype wire

### rtl/route_record_statistics_monitor_top.sv
`default_nettype none

// Route record statistics monitor. Each input transfer carries one command on
// in_tuser (add record, read dimension slot, read format slot, clear) and the
// record fields on in_tdata; each command produces exactly one result transfer
// that shows the statistics after the command. The block takes one command per
// clock cycle while the result register is not held by out_tready low. Each
// command passes through the input register and then the result register,
// which offers its result. All statistics and both table lookups are updated
// by combinational logic between those two registers, so the sustained rate of
// one command per cycle is limited only by the result register: while
// out_tready is low the result register holds and at most one more command is
// taken into the input register.
module route_record_statistics_monitor_top (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  // tdata, from bit 0 up: frame_width[15:0], frame_height[15:0],
  // format_code[15:0], payload_bytes[31:0], record_time[63:0],
  // altitude_mm[31:0], alt_valid, heading_mrad[15:0], hdg_valid,
  // slot_index[3:0], two zero pad bits.
  input  wire [199:0]  in_tdata,
  // tuser: command[1:0].
  input  wire [1:0]    in_tuser,
  output logic         out_tvalid,
  input  wire          out_tready,
  // tdata, from bit 0 up: records_seen[31:0], payload_total[47:0],
  // time_ordered, first_disorder_index[31:0], altitude_low[31:0],
  // altitude_high[31:0], heading_low[15:0], heading_high[15:0],
  // status_flags[3:0], unique_dimensions[4:0], unique_formats[4:0],
  // slot_value[31:0], one zero pad bit.
  output logic [255:0] out_tdata
);

  // Input register.
  logic                        item_valid_r;
  rrsm_pkg::cmd_t              cmd_r;
  logic [15:0]                 width_r;
  logic [15:0]                 height_r;
  logic [15:0]                 format_r;
  logic [31:0]                 payload_r;
  logic signed [63:0]          ts_r;
  logic signed [31:0]          alt_r;
  logic                        alt_known_r;
  logic signed [15:0]          head_r;
  logic                        head_known_r;
  logic [rrsm_pkg::SLOT_W-1:0] slot_r;

  // Statistics state.
  logic [31:0]        count_r,     count_nxt;
  logic [47:0]        sum_r,       sum_nxt;
  logic               ordered_r,   ordered_nxt;
  logic [31:0]        disorder_r,  disorder_nxt;
  logic signed [63:0] prev_ts_r,   prev_ts_nxt;
  logic signed [31:0] alt_lo_r,    alt_lo_nxt;
  logic signed [31:0] alt_hi_r,    alt_hi_nxt;
  logic signed [15:0] head_lo_r,   head_lo_nxt;
  logic signed [15:0] head_hi_r,   head_hi_nxt;
  logic [3:0]         flags_r,     flags_nxt;

  // Result register.
  logic         out_valid_r;
  logic [255:0] out_data_r, out_data_nxt;

  logic                advance;
  logic                commit;
  logic                is_add;
  logic                is_clear;
  logic [48:0]         sum_wide;
  logic [31:0]         slot_value;
  rrsm_pkg::tbl_req_t  dim_req, fmt_req;
  rrsm_pkg::tbl_resp_t dim_resp, fmt_resp;

  // Handshake: the result register moves when empty or taken.
  assign advance = !out_valid_r || out_tready;
  assign commit = item_valid_r && advance;
  assign in_tready = !item_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      item_valid_r <= 1'b1;
    end else if (commit) begin
      item_valid_r <= 1'b0;
    end
  end

  // Capture the input fields on each input transfer.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r        <= rrsm_pkg::cmd_t'(in_tuser);
      width_r      <= in_tdata[15:0];
      height_r     <= in_tdata[31:16];
      format_r     <= in_tdata[47:32];
      payload_r    <= in_tdata[79:48];
      ts_r         <= in_tdata[143:80];
      alt_r        <= in_tdata[175:144];
      alt_known_r  <= in_tdata[176];
      head_r       <= in_tdata[192:177];
      head_known_r <= in_tdata[193];
      slot_r       <= in_tdata[197:194];
    end
  end

  assign is_add = (cmd_r == rrsm_pkg::CMD_ADD);
  assign is_clear = (cmd_r == rrsm_pkg::CMD_CLEAR);

  // Lookup tables.
  always_comb begin
    dim_req.commit = commit;
    dim_req.add    = is_add;
    dim_req.clear  = is_clear;
    dim_req.value  = {width_r, height_r};
    dim_req.slot   = slot_r;
    fmt_req.commit = commit;
    fmt_req.add    = is_add;
    fmt_req.clear  = is_clear;
    fmt_req.value  = {16'd0, format_r};
    fmt_req.slot   = slot_r;
  end

  rrsm_table u_dim_table (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dim_req),
    .resp  (dim_resp)
  );

  rrsm_table u_fmt_table (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (fmt_req),
    .resp  (fmt_resp)
  );

  assign sum_wide = {1'b0, sum_r} + {17'd0, payload_r};

  // Next statistics for the item in the input register.
  always_comb begin
    count_nxt    = count_r;
    sum_nxt      = sum_r;
    ordered_nxt  = ordered_r;
    disorder_nxt = disorder_r;
    prev_ts_nxt  = prev_ts_r;
    alt_lo_nxt   = alt_lo_r;
    alt_hi_nxt   = alt_hi_r;
    head_lo_nxt  = head_lo_r;
    head_hi_nxt  = head_hi_r;
    flags_nxt    = flags_r;
    slot_value   = '0;
    case (cmd_r)
      rrsm_pkg::CMD_ADD: begin
        if (count_r != '1) begin
          count_nxt = count_r + 32'd1;
        end
        sum_nxt = sum_wide[48] ? '1 : sum_wide[47:0];
        if (ordered_r && !(prev_ts_r < ts_r)) begin
          ordered_nxt  = 1'b0;
          disorder_nxt = count_r;
        end
        prev_ts_nxt = ts_r;
        if (alt_known_r) begin
          flags_nxt[rrsm_pkg::FLAG_ALT_SEEN] = 1'b1;
          if (!flags_r[rrsm_pkg::FLAG_ALT_SEEN]) begin
            alt_lo_nxt = alt_r;
            alt_hi_nxt = alt_r;
          end else begin
            if (alt_r < alt_lo_r) alt_lo_nxt = alt_r;
            if (alt_r > alt_hi_r) alt_hi_nxt = alt_r;
          end
        end
        if (head_known_r) begin
          flags_nxt[rrsm_pkg::FLAG_HEAD_SEEN] = 1'b1;
          if (!flags_r[rrsm_pkg::FLAG_HEAD_SEEN]) begin
            head_lo_nxt = head_r;
            head_hi_nxt = head_r;
          end else begin
            if (head_r < head_lo_r) head_lo_nxt = head_r;
            if (head_r > head_hi_r) head_hi_nxt = head_r;
          end
        end
        if (dim_resp.ovf) flags_nxt[rrsm_pkg::FLAG_DIM_OVF] = 1'b1;
        if (fmt_resp.ovf) flags_nxt[rrsm_pkg::FLAG_FMT_OVF] = 1'b1;
      end
      rrsm_pkg::CMD_READ_DIM: begin
        slot_value = dim_resp.rd_data;
      end
      rrsm_pkg::CMD_READ_FMT: begin
        slot_value = fmt_resp.rd_data;
      end
      default: begin
        // Clear returns every statistic to its reset value.
        count_nxt    = '0;
        sum_nxt      = '0;
        ordered_nxt  = 1'b1;
        disorder_nxt = '0;
        prev_ts_nxt  = {1'b1, 63'd0};
        alt_lo_nxt   = '0;
        alt_hi_nxt   = '0;
        head_lo_nxt  = '0;
        head_hi_nxt  = '0;
        flags_nxt    = '0;
      end
    endcase
  end

  // Pack the result.
  always_comb begin
    out_data_nxt = {
      1'b0,
      slot_value,
      rrsm_pkg::COUNT_OUT_W'(fmt_resp.fill_nxt),
      rrsm_pkg::COUNT_OUT_W'(dim_resp.fill_nxt),
      flags_nxt,
      head_hi_nxt,
      head_lo_nxt,
      alt_hi_nxt,
      alt_lo_nxt,
      disorder_nxt,
      ordered_nxt,
      sum_nxt,
      count_nxt
    };
  end

  // Statistics registers, updated as each item moves into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      sum_r      <= '0;
      ordered_r  <= 1'b1;
      disorder_r <= '0;
      prev_ts_r  <= {1'b1, 63'd0};
      alt_lo_r   <= '0;
      alt_hi_r   <= '0;
      head_lo_r  <= '0;
      head_hi_r  <= '0;
      flags_r    <= '0;
    end else if (commit) begin
      count_r    <= count_nxt;
      sum_r      <= sum_nxt;
      ordered_r  <= ordered_nxt;
      disorder_r <= disorder_nxt;
      prev_ts_r  <= prev_ts_nxt;
      alt_lo_r   <= alt_lo_nxt;
      alt_hi_r   <= alt_hi_nxt;
      head_lo_r  <= head_lo_nxt;
      head_hi_r  <= head_hi_nxt;
      flags_r    <= flags_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= item_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/rrsm_checker.sv
`default_nettype none

module rrsm_checker (
  input wire         clk,
  input wire         rst_n,
  input wire         out_tvalid,
  input wire         out_tready,
  input wire [255:0] out_tdata
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // A stalled result keeps its data.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result data changed while stalled");

  // No result is offered right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

  // With no records counted, the payload total, ordering flag and both table counts are at their cleared values.
  a_empty_stats: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[31:0] == 32'd0) |->
      (out_tdata[79:32] == 48'd0) && out_tdata[80] &&
      (out_tdata[217:213] == 5'd0) && (out_tdata[222:218] == 5'd0))
    else $error("statistics nonzero with no records");

  // While ordered, the disorder index reads zero.
  a_ordered_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[80] |-> (out_tdata[112:81] == 32'd0))
    else $error("disorder index set while ordered");

endmodule

bind route_record_statistics_monitor_top rrsm_checker u_rrsm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

### tb/route_record_statistics_monitor_top_tb.sv
`default_nettype none

module route_record_statistics_monitor_top_tb;

  localparam int RANDOM_ITEMS = 1000;
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_PRINTED = 200;
  localparam int POOL_SIZE = 20;

  // One input transfer, laid out as on in_tdata (last member in bit 0).
  typedef struct packed {
    logic [1:0]                  pad;
    logic [rrsm_pkg::SLOT_W-1:0] slot_index;
    logic                        hdg_valid;
    logic signed [15:0]          heading_mrad;
    logic                        alt_valid;
    logic signed [31:0]          altitude_mm;
    logic signed [63:0]          record_time;
    logic [31:0]                 payload_bytes;
    logic [15:0]                 format_code;
    logic [15:0]                 frame_height;
    logic [15:0]                 frame_width;
  } route_record_t;

  // One result transfer, laid out as on out_tdata.
  typedef struct packed {
    logic               pad;
    logic [31:0]        slot_value;
    logic [4:0]         unique_formats;
    logic [4:0]         unique_dimensions;
    logic [3:0]         status_flags;
    logic signed [15:0] heading_high;
    logic signed [15:0] heading_low;
    logic signed [31:0] altitude_high;
    logic signed [31:0] altitude_low;
    logic [31:0]        first_disorder_index;
    logic               time_ordered;
    logic [47:0]        payload_total;
    logic [31:0]        records_seen;
  } stats_report_t;

  // Tracks the route statistics the block should hold and the reports it owes.
  class route_stats_tracker;
    logic [31:0]        rec_count;
    logic [47:0]        byte_total;
    logic               ordered;
    logic [31:0]        disorder_at;
    logic signed [63:0] last_ts;
    logic signed [31:0] alt_lo, alt_hi;
    logic signed [15:0] hdg_lo, hdg_hi;
    logic [3:0]         flags;
    logic [31:0]        dims [rrsm_pkg::TBL_SLOTS];
    logic [4:0]         dim_count;
    logic [15:0]        fmts [rrsm_pkg::TBL_SLOTS];
    logic [4:0]         fmt_count;
    stats_report_t      expected_reports [$];
    int                 mismatch_count;

    function new();
      mismatch_count = 0;
      clear_stats();
    endfunction

    function void clear_stats();
      rec_count = '0;
      byte_total = '0;
      ordered = 1'b1;
      disorder_at = '0;
      last_ts = 64'sh8000_0000_0000_0000;
      alt_lo = '0;
      alt_hi = '0;
      hdg_lo = '0;
      hdg_hi = '0;
      flags = '0;
      dim_count = '0;
      fmt_count = '0;
    endfunction

    // Apply one accepted command and queue the report it must produce.
    function void note_command(rrsm_pkg::cmd_t cmd, route_record_t rec);
      stats_report_t want;
      logic [31:0]   dim_key;
      logic [48:0]   wide_sum;
      logic          hit;
      want = '0;
      case (cmd)
        rrsm_pkg::CMD_ADD: begin
          // Distinct frame dimensions, dropped with overflow once full.
          dim_key = {rec.frame_width, rec.frame_height};
          hit = 1'b0;
          for (int i = 0; i < rrsm_pkg::TBL_SLOTS; i++)
            if (i < dim_count && dims[i] == dim_key) hit = 1'b1;
          if (!hit) begin
            if (dim_count < rrsm_pkg::TBL_SLOTS) begin
              dims[rrsm_pkg::TBL_IDX_W'(dim_count)] = dim_key;
              dim_count++;
            end else begin
              flags[rrsm_pkg::FLAG_DIM_OVF] = 1'b1;
            end
          end
          // Distinct format codes, same policy.
          hit = 1'b0;
          for (int i = 0; i < rrsm_pkg::TBL_SLOTS; i++)
            if (i < fmt_count && fmts[i] == rec.format_code) hit = 1'b1;
          if (!hit) begin
            if (fmt_count < rrsm_pkg::TBL_SLOTS) begin
              fmts[rrsm_pkg::TBL_IDX_W'(fmt_count)] = rec.format_code;
              fmt_count++;
            end else begin
              flags[rrsm_pkg::FLAG_FMT_OVF] = 1'b1;
            end
          end
          // Saturating payload total.
          wide_sum = {1'b0, byte_total} + {17'b0, rec.payload_bytes};
          byte_total = wide_sum[48] ? '1 : wide_sum[47:0];
          // The first timestamp that fails to strictly increase is latched.
          if (ordered && !($signed(last_ts) < $signed(rec.record_time))) begin
            ordered = 1'b0;
            disorder_at = rec_count;
          end
          last_ts = rec.record_time;
          // Extremes over known values only; the first known value seeds both.
          if (rec.alt_valid) begin
            if (!flags[rrsm_pkg::FLAG_ALT_SEEN]) begin
              alt_lo = rec.altitude_mm;
              alt_hi = rec.altitude_mm;
              flags[rrsm_pkg::FLAG_ALT_SEEN] = 1'b1;
            end else begin
              if ($signed(rec.altitude_mm) < alt_lo) alt_lo = rec.altitude_mm;
              if (alt_hi < $signed(rec.altitude_mm)) alt_hi = rec.altitude_mm;
            end
          end
          if (rec.hdg_valid) begin
            if (!flags[rrsm_pkg::FLAG_HEAD_SEEN]) begin
              hdg_lo = rec.heading_mrad;
              hdg_hi = rec.heading_mrad;
              flags[rrsm_pkg::FLAG_HEAD_SEEN] = 1'b1;
            end else begin
              if ($signed(rec.heading_mrad) < hdg_lo) hdg_lo = rec.heading_mrad;
              if (hdg_hi < $signed(rec.heading_mrad)) hdg_hi = rec.heading_mrad;
            end
          end
          if (rec_count != '1) rec_count++;
        end
        rrsm_pkg::CMD_READ_DIM: begin
          if (rec.slot_index < dim_count) want.slot_value = dims[rec.slot_index];
        end
        rrsm_pkg::CMD_READ_FMT: begin
          if (rec.slot_index < fmt_count) want.slot_value = {16'h0, fmts[rec.slot_index]};
        end
        default: begin
          clear_stats();
        end
      endcase
      want.records_seen = rec_count;
      want.payload_total = byte_total;
      want.time_ordered = ordered;
      want.first_disorder_index = disorder_at;
      want.altitude_low = alt_lo;
      want.altitude_high = alt_hi;
      want.heading_low = hdg_lo;
      want.heading_high = hdg_hi;
      want.status_flags = flags;
      want.unique_dimensions = dim_count;
      want.unique_formats = fmt_count;
      expected_reports.insert(expected_reports.size(), want);
    endfunction

    // Print at most a bounded number of lines, but count every mismatch.
    task report(string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED) $display("%0t: mismatch: %s", $time, msg);
    endtask

    task check_field(string label, logic [63:0] got, logic [63:0] want);
      if (got !== want) report($sformatf("%s got %0h expected %0h", label, got, want));
    endtask

    // Compare one result transfer against the oldest pending report.
    task check_report(stats_report_t got);
      stats_report_t want;
      if (expected_reports.size() == 0) begin
        report("result transfer with no expected report pending");
        return;
      end
      want = expected_reports.pop_front();
      check_field("records_seen", 64'(got.records_seen), 64'(want.records_seen));
      check_field("payload_total", 64'(got.payload_total), 64'(want.payload_total));
      check_field("time_ordered", 64'(got.time_ordered), 64'(want.time_ordered));
      check_field("first_disorder_index", 64'(got.first_disorder_index),
                  64'(want.first_disorder_index));
      check_field("altitude_low", 64'(got.altitude_low), 64'(want.altitude_low));
      check_field("altitude_high", 64'(got.altitude_high), 64'(want.altitude_high));
      check_field("heading_low", 64'(got.heading_low), 64'(want.heading_low));
      check_field("heading_high", 64'(got.heading_high), 64'(want.heading_high));
      check_field("status_flags", 64'(got.status_flags), 64'(want.status_flags));
      check_field("unique_dimensions", 64'(got.unique_dimensions),
                  64'(want.unique_dimensions));
      check_field("unique_formats", 64'(got.unique_formats), 64'(want.unique_formats));
      check_field("slot_value", 64'(got.slot_value), 64'(want.slot_value));
    endtask

    function int pending();
      return expected_reports.size();
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  wire          in_tready;
  logic [199:0] in_tdata;
  logic [1:0]   in_tuser;
  wire          out_tvalid;
  logic         out_tready;
  wire  [255:0] out_tdata;

  route_stats_tracker tracker;
  int                 idle_cycles;
  logic [31:0]        dim_pool [POOL_SIZE];
  logic [15:0]        fmt_pool [POOL_SIZE];
  logic signed [63:0] ts_cursor;

  route_record_statistics_monitor_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Observe both channels at the rising edge; results are checked before the
  // input of the same edge is noted, though latency keeps them apart anyway.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) tracker.check_report(out_tdata);
      if (in_tvalid && in_tready) tracker.note_command(rrsm_pkg::cmd_t'(in_tuser), in_tdata);
    end
  end

  // Watchdog: end the run if no transfer happens on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Receiver back-pressure: stretches of free flow, light and heavy random
  // stalls, and a periodic stall pattern.
  initial begin
    int mode;
    int span;
    out_tready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      for (int i = 0; i < span; i++) begin
        @(negedge clk);
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 3) != 0);
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= (i % 4 == 0);
        endcase
      end
    end
  end

  // Hold one command on the input until it is taken; returns at a falling edge.
  task automatic send_command(rrsm_pkg::cmd_t cmd, route_record_t rec);
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= rec;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  function automatic route_record_t random_record();
    route_record_t rec;
    rec.pad = '0;
    rec.slot_index = rrsm_pkg::SLOT_W'($urandom_range(0, 15));
    rec.hdg_valid = 1'($urandom_range(0, 1));
    rec.heading_mrad = 16'($urandom);
    rec.alt_valid = 1'($urandom_range(0, 1));
    rec.altitude_mm = $urandom;
    rec.record_time = {$urandom, $urandom};
    rec.payload_bytes = $urandom;
    rec.format_code = 16'($urandom);
    rec.frame_height = 16'($urandom);
    rec.frame_width = 16'($urandom);
    return rec;
  endfunction

  // Sender gap with junk on the data lines; an argument of zero means back to back.
  task automatic idle_sender(int cycles);
    if (cycles == 0) return;
    in_tvalid <= 1'b0;
    in_tuser <= rrsm_pkg::cmd_t'($urandom_range(0, 3));
    in_tdata <= random_record();
    repeat (cycles) @(negedge clk);
  endtask

  function automatic route_record_t add_record(logic [15:0] w, logic [15:0] h,
                                               logic [15:0] fmt, logic [31:0] pay,
                                               logic [63:0] ts, logic [31:0] alt,
                                               logic alt_ok, logic [15:0] hdg,
                                               logic hdg_ok);
    route_record_t rec;
    rec = '0;
    rec.frame_width = w;
    rec.frame_height = h;
    rec.format_code = fmt;
    rec.payload_bytes = pay;
    rec.record_time = ts;
    rec.altitude_mm = alt;
    rec.alt_valid = alt_ok;
    rec.heading_mrad = hdg;
    rec.hdg_valid = hdg_ok;
    return rec;
  endfunction

  function automatic route_record_t slot_request(logic [3:0] slot);
    route_record_t rec;
    rec = '0;
    rec.slot_index = slot;
    return rec;
  endfunction

  // A plausible record: mostly rising timestamps, dimensions and formats
  // drawn from small pools so the tables fill and overflow between clears.
  function automatic route_record_t next_route_record();
    route_record_t rec;
    int            pick;
    rec = random_record();
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      ts_cursor = ts_cursor;
    end else if (pick < 6) begin
      ts_cursor = {$urandom, $urandom};
    end else if (pick < 8) begin
      ts_cursor = ts_cursor - $urandom_range(1, 1000);
    end else begin
      ts_cursor = ts_cursor + $urandom_range(1, 1 << 20);
    end
    rec.record_time = ts_cursor;
    if ($urandom_range(0, 99) < 85) begin
      {rec.frame_width, rec.frame_height} = dim_pool[$urandom_range(0, POOL_SIZE - 1)];
    end
    if ($urandom_range(0, 99) < 85) rec.format_code = fmt_pool[$urandom_range(0, POOL_SIZE - 1)];
    if ($urandom_range(0, 1)) rec.altitude_mm = $urandom_range(0, 2000) - 1000;
    rec.alt_valid = ($urandom_range(0, 3) != 0);
    rec.hdg_valid = ($urandom_range(0, 3) != 0);
    return rec;
  endfunction

  // Main sequence: reset, directed cases, random traffic, drain, verdict.
  initial begin
    int             pick;
    int             burst;
    int             sent;
    rrsm_pkg::cmd_t cmd;
    tracker = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = rrsm_pkg::CMD_ADD;
    for (int i = 0; i < POOL_SIZE; i++) begin
      dim_pool[i] = $urandom;
      fmt_pool[i] = 16'($urandom);
    end
    ts_cursor = {$urandom, $urandom};
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // First record at the most negative timestamp is already out of order.
    send_command(rrsm_pkg::CMD_ADD, add_record(16'h0, 16'h0, 16'h0, 32'h0,
                                               64'h8000_0000_0000_0000,
                                               32'h8000_0000, 1'b1, 16'h8000, 1'b1));
    send_command(rrsm_pkg::CMD_ADD, add_record(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                                               64'h7FFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF, 1'b1,
                                               16'h7FFF, 1'b1));
    // Duplicate table values, equal timestamp, unknown altitude and heading.
    send_command(rrsm_pkg::CMD_ADD, add_record(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                                               64'h7FFF_FFFF_FFFF_FFFF, 32'd123, 1'b0,
                                               16'hFFFB, 1'b0));
    // Filled, then empty slots of both tables.
    send_command(rrsm_pkg::CMD_READ_DIM, slot_request(4'd0));
    send_command(rrsm_pkg::CMD_READ_DIM, slot_request(4'd1));
    send_command(rrsm_pkg::CMD_READ_DIM, slot_request(4'd15));
    send_command(rrsm_pkg::CMD_READ_FMT, slot_request(4'd0));
    send_command(rrsm_pkg::CMD_READ_FMT, slot_request(4'd1));
    send_command(rrsm_pkg::CMD_READ_FMT, slot_request(4'd15));
    send_command(rrsm_pkg::CMD_CLEAR, random_record());
    // Ordered start, then an equal timestamp marks disorder at index 2.
    send_command(rrsm_pkg::CMD_ADD, add_record(16'd640, 16'd480, 16'h20, 32'd1000, -64'sd5,
                                               -32'sd100, 1'b1, 16'd300, 1'b1));
    send_command(rrsm_pkg::CMD_ADD, add_record(16'd1280, 16'd720, 16'h21, 32'd2000, 64'sd7,
                                               32'sd50, 1'b1, -16'sd300, 1'b1));
    send_command(rrsm_pkg::CMD_ADD, add_record(16'd640, 16'd480, 16'h20, 32'd3000, 64'sd7,
                                               32'sd0, 1'b1, 16'd0, 1'b0));
    send_command(rrsm_pkg::CMD_ADD, add_record(16'd320, 16'd240, 16'h22, 32'd4000, 64'sd1,
                                               32'sd0, 1'b0, 16'd0, 1'b1));
    send_command(rrsm_pkg::CMD_READ_DIM, slot_request(4'd1));
    send_command(rrsm_pkg::CMD_READ_FMT, slot_request(4'd3));
    // After a clear the tables read empty and ordering starts over.
    send_command(rrsm_pkg::CMD_CLEAR, random_record());
    send_command(rrsm_pkg::CMD_READ_DIM, slot_request(4'd0));
    send_command(rrsm_pkg::CMD_ADD, add_record(16'd1, 16'd2, 16'd3, 32'd4,
                                               64'h8000_0000_0000_0001,
                                               32'sd9, 1'b1, 16'd9, 1'b1));
    send_command(rrsm_pkg::CMD_READ_FMT, slot_request(4'd0));
    send_command(rrsm_pkg::CMD_CLEAR, random_record());

    // Random traffic in bursts with gaps of varying length.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 74) begin
          send_command(rrsm_pkg::CMD_ADD, next_route_record());
        end else if (pick < 98) begin
          cmd = (pick < 86) ? rrsm_pkg::CMD_READ_DIM : rrsm_pkg::CMD_READ_FMT;
          send_command(cmd, random_record());
        end else begin
          send_command(rrsm_pkg::CMD_CLEAR, random_record());
          ts_cursor = {$urandom, $urandom};
        end
        sent++;
      end
      pick = $urandom_range(0, 9);
      if (pick < 4) idle_sender(0);
      else if (pick < 9) idle_sender($urandom_range(1, 4));
      else idle_sender($urandom_range(5, 30));
    end
    in_tvalid <= 1'b0;

    // Drain, then allow the pipeline to settle before the verdict.
    while (tracker.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
rtl/rrsm_pkg.sv
rtl/rrsm_table.sv
rtl/route_record_statistics_monitor_top.sv
rtl/rrsm_checker.sv
tb/route_record_statistics_monitor_top_tb.sv
